### hw/rtl/uart_rb_pkg.sv
`default_nettype none

package uart_rb_pkg;

  localparam int unsigned DefFifoDepth = 16;

  typedef enum logic [1:0] {
    KindRxByte = 2'd0,
    KindRead   = 2'd1,
    KindWrite  = 2'd2,
    KindNone   = 2'd3
  } kind_e;

  localparam logic [2:0] OffRbrThr = 3'd0;
  localparam logic [2:0] OffIer    = 3'd1;
  localparam logic [2:0] OffIirFcr = 3'd2;
  localparam logic [2:0] OffLcr    = 3'd3;
  localparam logic [2:0] OffMcr    = 3'd4;
  localparam logic [2:0] OffLsr    = 3'd5;
  localparam logic [2:0] OffMsr    = 3'd6;
  localparam logic [2:0] OffScr    = 3'd7;

  localparam logic [7:0] IirRxData  = 8'h04;
  localparam logic [7:0] IirTxEmpty = 8'h02;
  localparam logic [7:0] IirNone    = 8'h01;
  localparam logic [7:0] LsrBase    = 8'h60;

endpackage

`default_nettype wire

### hw/rtl/uart_register_block_rx_fifo.sv
`default_nettype none

// Simplified 16550-style register block with a receive FIFO. An item (received
// byte, bus read or bus write) is taken whenever start_i is high; busy_o is
// always low, so a new item may follow in every cycle. Each item gives exactly
// one result, loaded into the result register at the clock edge after it is
// taken: the input register feeds the register and FIFO update. The result
// sits on the output ports for one cycle marked by done_o and must be taken
// then: the receiver cannot stall the block. The FIFO head byte is kept
// pre-read in a register so the FIFO store needs a single read port.
module uart_register_block_rx_fifo
  import uart_rb_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = DefFifoDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [2:0] reg_offset_i,
  input  wire logic [7:0] write_data_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            done_o,
  output logic [7:0]      read_data_o,
  output logic            irq_raised_o,
  output logic            tx_valid_o,
  output logic [7:0]      tx_byte_o
);

  localparam int unsigned PtrW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FillW = $clog2(FIFO_DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(FIFO_DEPTH - 1);
  localparam logic [FillW-1:0] FillMax = FillW'(FIFO_DEPTH);

  // input register
  logic       s1_valid_q;
  kind_e      s1_kind_q;
  logic [2:0] s1_off_q;
  logic [7:0] s1_wd_q;
  logic [7:0] s1_rb_q;

  // block state
  logic [PtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       ier_q, ier_d, lcr_q, lcr_d, mcr_q, mcr_d, scr_q, scr_d;
  logic [7:0]       dll_q, dll_d, dlm_q, dlm_d;
  logic             pend_q, pend_d;
  logic [7:0]       front_q;
  logic [7:0]       rx_mem [FIFO_DEPTH];

  logic       push, pop, dlab, irq_chk, irq_d, txv_d;
  logic [7:0] rd_d, txb_d;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      s1_kind_q <= kind_e'(kind_i);
      s1_off_q  <= reg_offset_i;
      s1_wd_q   <= write_data_i;
      s1_rb_q   <= rx_byte_i;
    end
  end

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    ier_d  = ier_q;
    lcr_d  = lcr_q;
    mcr_d  = mcr_q;
    scr_d  = scr_q;
    dll_d  = dll_q;
    dlm_d  = dlm_q;
    pend_d = pend_q;
    push   = 1'b0;
    pop    = 1'b0;
    irq_d  = 1'b0;
    txv_d  = 1'b0;
    txb_d  = 8'h00;
    rd_d   = 8'h00;
    dlab   = lcr_q[7];
    irq_chk = 1'b0;
    if (s1_valid_q) begin
      case (s1_kind_q)
        KindRxByte: begin
          push = (fill_q != FillMax);
        end
        KindRead: begin
          if (dlab && (s1_off_q == OffRbrThr || s1_off_q == OffIer)) begin
            rd_d = (s1_off_q == OffRbrThr) ? dll_q : dlm_q;
          end else begin
            case (s1_off_q)
              OffRbrThr: begin
                if (fill_q != '0) begin
                  pop  = 1'b1;
                  rd_d = front_q;
                end
                irq_chk = 1'b1;
              end
              OffIer: rd_d = ier_q;
              OffIirFcr: begin
                if (fill_q != '0 && ier_q[0]) begin
                  rd_d = IirRxData;
                end else if (pend_q && ier_q[1]) begin
                  rd_d   = IirTxEmpty;
                  pend_d = 1'b0;
                end else begin
                  rd_d = IirNone;
                end
              end
              OffLcr: rd_d = lcr_q;
              OffMcr: rd_d = mcr_q;
              OffLsr: rd_d = LsrBase | {7'd0, fill_q != '0};
              OffMsr: rd_d = 8'h00;
              default: rd_d = scr_q;
            endcase
          end
        end
        KindWrite: begin
          if (dlab && (s1_off_q == OffRbrThr || s1_off_q == OffIer)) begin
            if (s1_off_q == OffRbrThr) begin
              dll_d = s1_wd_q;
            end else begin
              dlm_d = s1_wd_q;
            end
          end else begin
            case (s1_off_q)
              OffRbrThr: begin
                txv_d   = 1'b1;
                txb_d   = s1_wd_q;
                pend_d  = 1'b1;
                irq_chk = 1'b1;
              end
              OffIer: begin
                if (s1_wd_q[1] && !ier_q[1]) begin
                  pend_d = 1'b1;
                end
                ier_d   = s1_wd_q;
                irq_chk = 1'b1;
              end
              OffLcr: lcr_d = s1_wd_q;
              OffMcr: mcr_d = s1_wd_q;
              OffScr: scr_d = s1_wd_q;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
    if (push) begin
      tail_d = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
      fill_d = fill_q + 1'b1;
    end
    if (pop) begin
      head_d = (head_q == PtrLast) ? '0 : head_q + 1'b1;
      fill_d = fill_q - 1'b1;
    end
    if (irq_chk) begin
      irq_d = (ier_d[1] && pend_d) || (ier_d[0] && fill_d != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      ier_q        <= '0;
      lcr_q        <= '0;
      mcr_q        <= '0;
      scr_q        <= '0;
      dll_q        <= '0;
      dlm_q        <= '0;
      pend_q       <= 1'b0;
      done_o       <= 1'b0;
      irq_raised_o <= 1'b0;
      tx_valid_o   <= 1'b0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      fill_q       <= fill_d;
      ier_q        <= ier_d;
      lcr_q        <= lcr_d;
      mcr_q        <= mcr_d;
      scr_q        <= scr_d;
      dll_q        <= dll_d;
      dlm_q        <= dlm_d;
      pend_q       <= pend_d;
      done_o       <= s1_valid_q;
      irq_raised_o <= irq_d;
      tx_valid_o   <= txv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    read_data_o <= rd_d;
    tx_byte_o   <= txb_d;
  end

  // fifo store with the next head byte read ahead
  always_ff @(posedge clk_i) begin
    if (push) begin
      rx_mem[tail_q] <= s1_rb_q;
    end
    if (push && tail_q == head_d) begin
      front_q <= s1_rb_q;
    end else begin
      front_q <= rx_mem[head_d];
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax) else $error("fifo fill above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) |-> (head_q == tail_q)) else $error("empty fifo with apart pointers");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> done_o) else $error("item without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |=> !done_o) else $error("result without item");

  a_side_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_valid_o || irq_raised_o) |-> done_o) else $error("flag outside result");

endmodule

`default_nettype wire
